FILE: rtl/core/stdp_pkg.sv
// Package with shared types, constants and register codes for the STDP synapse block.
`timescale 1ns / 1ps
package stdp_pkg;

	localparam int SYNAPSES_DEF = 1024;
	localparam int NEURONS_DEF  = 256;
	localparam int IDX_W        = 10;
	localparam int NRN_W        = 8;
	localparam int W_W          = 16;
	localparam int T_W          = 16;
	localparam int SUM_W        = 24;
	localparam int DIV_STEPS    = 40;
	localparam int CNT_W        = 6;

	localparam logic [W_W-1:0]   WEIGHT_ONE = 16'd32768;
	localparam logic [T_W-1:0]   TRACE_ONE  = 16'd1024;
	localparam logic [SUM_W-1:0] SUM_MAX    = 24'hFFFFFF;

	typedef enum logic [1:0] {
		REQ_UPDATE = 2'd0,
		REQ_NORM   = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		REG_DECAY = 3'd0,
		REG_POT   = 3'd1,
		REG_DEP   = 3'd2,
		REG_FLOOR = 3'd3,
		REG_CEIL  = 3'd4,
		REG_LIMIT = 3'd5
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_RD,
		ST_DEC,
		ST_RATE,
		ST_WGT,
		ST_DIV,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] synapse_index;
		logic [NRN_W-1:0] post_neuron;
		logic             pre_spiked;
		logic             post_spiked;
		logic             past_startup;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] echo_index;
		logic [W_W-1:0]   new_weight;
		logic [SUM_W-1:0] target_sum;
		logic             was_scaled;
	} out_word_t;

	typedef struct packed {
		logic [T_W-1:0]   trace_decay;
		logic [15:0]      potentiation_rate;
		logic [15:0]      depression_rate;
		logic [W_W-1:0]   weight_floor;
		logic [W_W-1:0]   weight_ceiling;
		logic [SUM_W-1:0] total_in_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd;
		logic dec;
		logic rate;
		logic wgt;
		logic div_start;
		logic div_step;
		logic wb;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_needed;
		logic div_done;
		req_t req;
	} sts_t;

endpackage

FILE: rtl/core/stdp_cfg_regs.sv
// APB configuration register file for the STDP synapse block.
`timescale 1ns / 1ps
module stdp_cfg_regs
	import stdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trace_decay       <= 16'd64238;
			cfg_q.potentiation_rate <= 16'd655;
			cfg_q.depression_rate   <= 16'd328;
			cfg_q.weight_floor      <= 16'd328;
			cfg_q.weight_ceiling    <= 16'd32768;
			cfg_q.total_in_limit    <= 24'd163840;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DECAY: cfg_q.trace_decay       <= pwdata[15:0];
				REG_POT:   cfg_q.potentiation_rate <= pwdata[15:0];
				REG_DEP:   cfg_q.depression_rate   <= pwdata[15:0];
				REG_FLOOR: cfg_q.weight_floor      <= pwdata[15:0];
				REG_CEIL:  cfg_q.weight_ceiling    <= pwdata[15:0];
				REG_LIMIT: cfg_q.total_in_limit    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DECAY: prdata = {16'd0, cfg_q.trace_decay};
			REG_POT:   prdata = {16'd0, cfg_q.potentiation_rate};
			REG_DEP:   prdata = {16'd0, cfg_q.depression_rate};
			REG_FLOOR: prdata = {16'd0, cfg_q.weight_floor};
			REG_CEIL:  prdata = {16'd0, cfg_q.weight_ceiling};
			REG_LIMIT: prdata = {8'd0, cfg_q.total_in_limit};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/core/stdp_ctrl.sv
// Controller FSM sequencing clear, update, normalize and no-op items.
`timescale 1ns / 1ps
module stdp_ctrl
	import stdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_RD;
			ST_CLR:  if (sts.clr_done) state_d = ST_IDLE;
			ST_RD:   state_d = ST_DEC;
			ST_DEC: begin
				if (sts.req == REQ_UPDATE) state_d = ST_RATE;
				else if (sts.req == REQ_NORM && sts.div_needed) state_d = ST_DIV;
				else state_d = ST_WB;
			end
			ST_RATE: state_d = ST_WGT;
			ST_WGT:  state_d = ST_WB;
			ST_DIV:  if (sts.div_done) state_d = ST_WB;
			ST_WB:   state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_CLR:  cmd.clr_step = 1'b1;
			ST_RD:   cmd.rd = 1'b1;
			ST_DEC: begin
				cmd.dec = 1'b1;
				cmd.div_start = (sts.req == REQ_NORM) && sts.div_needed;
			end
			ST_RATE: cmd.rate = 1'b1;
			ST_WGT:  cmd.wgt = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_WB:   cmd.wb = 1'b1;
			ST_OUT:  cmd.emit = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/stdp_datapath.sv
// Datapath with synapse and sum memories, trace arithmetic and a serial divider.
`timescale 1ns / 1ps
module stdp_datapath
	import stdp_pkg::*;
#(
	parameter int SYNAPSES = SYNAPSES_DEF,
	parameter int NEURONS  = NEURONS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_word_t  in_word,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_word_t out_word,
	output logic      out_valid
);

	localparam int SA_W = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
	localparam int NA_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int CLR_N = (SYNAPSES > NEURONS) ? SYNAPSES : NEURONS;
	localparam int CL_W = $clog2(CLR_N + 1);

	logic [W_W+2*T_W-1:0] syn_mem [SYNAPSES];
	logic [SUM_W-1:0]     sum_mem [NEURONS];

	in_word_t         item_q;
	logic [SA_W-1:0]  sa_q;
	logic [NA_W-1:0]  na_q;
	logic [CL_W-1:0]  clr_q;
	logic [W_W-1:0]   w_q;
	logic [T_W-1:0]   pt_q, qt_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      pprod_q, dprod_q;
	logic [W_W-1:0]   wnew_q;
	logic [SUM_W-1:0] sum_new_q;
	logic             scaled_q;
	logic [39:0]      num_q;
	logic [SUM_W:0]   rem_q;
	logic [CNT_W-1:0] dcnt_q;
	out_word_t        out_q;
	logic             out_v_q;

	logic [SA_W-1:0]  clr_sa;
	logic [NA_W-1:0]  clr_na;
	logic [31:0]      pdec, qdec;
	logic [T_W:0]     pbump, qbump;
	logic [T_W-1:0]   pt_d, qt_d;
	logic             pb, qb;
	logic [23:0]      wsum;
	logic [23:0]      wcl;
	logic [SUM_W:0]   ssum;
	logic [SUM_W:0]   rtry;
	logic [SUM_W:0]   rsh;

	assign clr_sa = clr_q[SA_W-1:0];
	assign clr_na = clr_q[NA_W-1:0];

	assign pdec  = pt_q * cfg.trace_decay + 32'd32768;
	assign qdec  = qt_q * cfg.trace_decay + 32'd32768;
	assign pb    = item_q.pre_spiked & item_q.past_startup;
	assign qb    = item_q.post_spiked & item_q.past_startup;
	assign pbump = {1'b0, pdec[31:16]} + (pb ? {1'b0, TRACE_ONE} : 17'd0);
	assign qbump = {1'b0, qdec[31:16]} + (qb ? {1'b0, TRACE_ONE} : 17'd0);
	assign pt_d  = pbump[T_W] ? 16'hFFFF : pbump[T_W-1:0];
	assign qt_d  = qbump[T_W] ? 16'hFFFF : qbump[T_W-1:0];

	// Signed 24-bit weight: add potentiation, subtract depression, then clamp.
	always_comb begin
		wsum = {8'd0, w_q};
		if (item_q.post_spiked) wsum = wsum + {3'd0, pprod_q[31:11]};
		if (item_q.pre_spiked)  wsum = wsum - {3'd0, dprod_q[31:11]};
		wcl = wsum;
		if ($signed(wcl) < $signed({8'd0, cfg.weight_floor})) wcl = {8'd0, cfg.weight_floor};
		if ($signed(wcl) > $signed({8'd0, cfg.weight_ceiling})) wcl = {8'd0, cfg.weight_ceiling};
	end

	assign ssum = {1'b0, sum_q} + {9'd0, wnew_q};
	assign rsh  = {rem_q[SUM_W-1:0], num_q[39]};
	assign rtry = rsh - {1'b0, sum_q};

	assign sts.clr_done   = (clr_q == CL_W'(CLR_N - 1));
	assign sts.div_needed = sum_q > cfg.total_in_limit;
	assign sts.div_done   = (dcnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.req        = req_t'(item_q.req_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			out_v_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			out_v_q <= cmd.emit;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			if (clr_q < CL_W'(SYNAPSES)) syn_mem[clr_sa] <= {WEIGHT_ONE, 32'd0};
			if (clr_q < CL_W'(NEURONS))  sum_mem[clr_na] <= '0;
		end
		if (cmd.load) begin
			item_q <= in_word;
			sa_q   <= SA_W'(in_word.synapse_index % SYNAPSES);
			na_q   <= NA_W'(in_word.post_neuron % NEURONS);
		end
		if (cmd.rd) begin
			{w_q, pt_q, qt_q} <= syn_mem[sa_q];
			sum_q             <= sum_mem[na_q];
			scaled_q          <= 1'b0;
		end
		if (cmd.dec) begin
			if (sts.req == REQ_UPDATE) begin
				pt_q <= pt_d;
				qt_q <= qt_d;
			end
			wnew_q <= w_q;
		end
		if (cmd.div_start) begin
			num_q <= w_q * cfg.total_in_limit;
			rem_q <= '0;
		end
		if (cmd.rate) begin
			pprod_q <= cfg.potentiation_rate * pt_q + 32'd1024;
			dprod_q <= cfg.depression_rate * qt_q + 32'd1024;
		end
		if (cmd.wgt) wnew_q <= wcl[W_W-1:0];
		if (cmd.div_step) begin
			if (!rtry[SUM_W]) begin
				rem_q <= rtry;
				num_q <= {num_q[38:0], 1'b1};
			end else begin
				rem_q <= rsh;
				num_q <= {num_q[38:0], 1'b0};
			end
			if (sts.div_done) begin
				wnew_q   <= {num_q[14:0], !rtry[SUM_W]};
				scaled_q <= ({num_q[14:0], !rtry[SUM_W]} < w_q);
			end
		end
		if (cmd.wb) begin
			unique case (sts.req)
				REQ_UPDATE: begin
					syn_mem[sa_q] <= {wnew_q, pt_q, qt_q};
					sum_new_q <= ssum[SUM_W] ? SUM_MAX : ssum[SUM_W-1:0];
					sum_mem[na_q] <= ssum[SUM_W] ? SUM_MAX : ssum[SUM_W-1:0];
				end
				REQ_NORM: begin
					syn_mem[sa_q] <= {wnew_q, pt_q, qt_q};
					sum_new_q <= sum_q;
				end
				REQ_CLEAR: begin
					sum_mem[na_q] <= '0;
					sum_new_q <= '0;
				end
				default: sum_new_q <= sum_q;
			endcase
		end
		if (cmd.emit) begin
			out_q.echo_index <= item_q.synapse_index;
			out_q.new_weight <= wnew_q;
			out_q.target_sum <= sum_new_q;
			out_q.was_scaled <= scaled_q;
		end
	end

	assign out_word  = out_q;
	assign out_valid = out_v_q;

endmodule

FILE: rtl/core/stdp_synapse_weight_update.sv
// Top level of the STDP synapse weight update block.
//  channel | signals                         | handshake
//  input   | start, busy, in_word            | taken when start and not busy
//  result  | done, out_word                  | one-cycle strobe, no stall
//  config  | psel..pready, APB               | write on access phase
// Update: read, decay, rate, weight, write-back, output. Clear, no-op and
// unscaled normalize skip rate and weight; scaled normalize uses the 40-step
// restoring divider. After reset, clearing all entries holds busy high.
// Results cannot be stalled; each item yields one done strobe.
`timescale 1ns / 1ps
module stdp_synapse_weight_update
	import stdp_pkg::*;
#(
	parameter int SYNAPSES = SYNAPSES_DEF,
	parameter int NEURONS  = NEURONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    in_word,
	output logic        done,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	stdp_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	stdp_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .cmd);

	stdp_datapath #(.SYNAPSES(SYNAPSES), .NEURONS(NEURONS)) u_dp (
		.clk, .arst_n, .cfg, .in_word, .cmd, .sts, .out_word, .out_valid(done)
	);

endmodule

FILE: rtl/core/stdp_checker.sv
// Port-level checker for the STDP synapse block, bound to the top level.
`timescale 1ns / 1ps
module stdp_checker
	import stdp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_word_t out_word,
	input logic      pready
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without item");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_word.new_weight <= WEIGHT_ONE || out_word.was_scaled == 1'b0)
		else $error("scaled weight out of range");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind stdp_synapse_weight_update stdp_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .out_word, .pready
);

FILE: tb/testbench.sv
// Self-checking testbench for the STDP synapse weight update block.
`timescale 1ns / 1ps
module testbench;
	import stdp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_word_t    in_word = '0;
	logic        done;
	out_word_t   out_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	stdp_synapse_weight_update DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .out_word(out_word), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	logic [15:0] cfg_decay, cfg_pot, cfg_dep, cfg_floor, cfg_ceil;
	logic [23:0] cfg_limit;
	logic [15:0] weight_mem [SYNAPSES_DEF];
	logic [15:0] pre_tr_mem [SYNAPSES_DEF];
	logic [15:0] post_tr_mem [SYNAPSES_DEF];
	logic [23:0] sum_mem [NEURONS_DEF];

	out_word_t expected_words[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int scaled_seen = 0;
	bit no_idle = 1'b0;

	function automatic logic [15:0] decay_trace(logic [15:0] t, bit bump);
		logic [63:0] v;
		v = ({48'd0, t} * {48'd0, cfg_decay} + 64'd32768) >> 16;
		if (bump) begin
			v = v + 64'd1024;
			if (v > 64'd65535) v = 64'd65535;
		end
		return v[15:0];
	endfunction

	function automatic logic [63:0] rate_change(logic [15:0] rate, logic [15:0] t);
		return ({48'd0, rate} * {48'd0, t} + 64'd1024) >> 11;
	endfunction

	function automatic out_word_t predict_synapse(in_word_t w);
		out_word_t r;
		int unsigned s, n;
		logic [15:0] pt, qt;
		longint wt;
		logic [63:0] sum, nw;
		s = w.synapse_index % SYNAPSES_DEF;
		n = w.post_neuron % NEURONS_DEF;
		r = '0;
		case (req_t'(w.req_type))
			REQ_UPDATE: begin
				pt = decay_trace(pre_tr_mem[s], w.pre_spiked && w.past_startup);
				qt = decay_trace(post_tr_mem[s], w.post_spiked && w.past_startup);
				pre_tr_mem[s] = pt;
				post_tr_mem[s] = qt;
				wt = longint'(weight_mem[s]);
				if (w.post_spiked) wt = wt + longint'(rate_change(cfg_pot, pt));
				if (w.pre_spiked) wt = wt - longint'(rate_change(cfg_dep, qt));
				if (wt < longint'(cfg_floor)) wt = longint'(cfg_floor);
				if (wt > longint'(cfg_ceil)) wt = longint'(cfg_ceil);
				weight_mem[s] = wt[15:0];
				sum = {40'd0, sum_mem[n]} + {48'd0, wt[15:0]};
				if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
				sum_mem[n] = sum[23:0];
			end
			REQ_NORM: begin
				if (sum_mem[n] > cfg_limit) begin
					nw = ({48'd0, weight_mem[s]} * {40'd0, cfg_limit}) / {40'd0, sum_mem[n]};
					if (nw[15:0] < weight_mem[s]) r.was_scaled = 1'b1;
					weight_mem[s] = nw[15:0];
				end
			end
			REQ_CLEAR: sum_mem[n] = '0;
			default: ;
		endcase
		r.echo_index = w.synapse_index;
		r.new_weight = weight_mem[s];
		r.target_sum = sum_mem[n];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_word);
				errors++;
			end else begin
				out_word_t e;
				e = expected_words.pop_front();
				words_checked++;
				if (out_word.was_scaled) scaled_seen++;
				if (out_word.echo_index !== e.echo_index) begin
					$display("%0t: echo_index expected %0d actual %0d", $time,
						e.echo_index, out_word.echo_index);
					errors++;
				end
				if (out_word.new_weight !== e.new_weight) begin
					$display("%0t: new_weight expected %0d actual %0d", $time,
						e.new_weight, out_word.new_weight);
					errors++;
				end
				if (out_word.target_sum !== e.target_sum) begin
					$display("%0t: target_sum expected %0d actual %0d", $time,
						e.target_sum, out_word.target_sum);
					errors++;
				end
				if (out_word.was_scaled !== e.was_scaled) begin
					$display("%0t: was_scaled expected %0d actual %0d", $time,
						e.was_scaled, out_word.was_scaled);
					errors++;
				end
			end
		end
	end

	task automatic send_word(in_word_t w);
		if (!no_idle && $urandom_range(0, 99) < 34) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		in_word <= w;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		expected_words.push_back(predict_synapse(w));
		words_sent++;
	endtask

	task automatic drain_block();
		@(negedge clk);
		start <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (60) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(reg_t r, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (r)
			REG_DECAY: cfg_decay = v[15:0];
			REG_POT:   cfg_pot = v[15:0];
			REG_DEP:   cfg_dep = v[15:0];
			REG_FLOOR: cfg_floor = v[15:0];
			REG_CEIL:  cfg_ceil = v[15:0];
			REG_LIMIT: cfg_limit = v[23:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] d, logic [15:0] p, logic [15:0] q,
			logic [15:0] f, logic [15:0] c, logic [23:0] l);
		drain_block();
		write_reg(REG_DECAY, {16'd0, d});
		write_reg(REG_POT, {16'd0, p});
		write_reg(REG_DEP, {16'd0, q});
		write_reg(REG_FLOOR, {16'd0, f});
		write_reg(REG_CEIL, {16'd0, c});
		write_reg(REG_LIMIT, {8'd0, l});
	endtask

	function automatic in_word_t make_word(logic [1:0] t, logic [9:0] s, logic [7:0] n,
			bit pre, bit post, bit past);
		in_word_t w;
		w.req_type = t;
		w.synapse_index = s;
		w.post_neuron = n;
		w.pre_spiked = pre;
		w.post_spiked = post;
		w.past_startup = past;
		return w;
	endfunction

	function automatic in_word_t random_word();
		int unsigned k;
		logic [1:0] t;
		logic [9:0] s;
		logic [7:0] n;
		k = $urandom_range(0, 99);
		if (k < 60) t = REQ_UPDATE;
		else if (k < 82) t = REQ_NORM;
		else if (k < 92) t = REQ_CLEAR;
		else t = REQ_NONE;
		if ($urandom_range(0, 9) < 8) begin
			s = 10'($urandom_range(0, 7));
			if ($urandom_range(0, 1)) s = s | 10'h3F8;
			n = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			n = n ^ 8'($urandom_range(0, 1));
		end else begin
			s = 10'($urandom_range(0, 1023));
			n = 8'($urandom_range(0, 255));
		end
		return make_word(t, s, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom_range(0, 9) != 0);
	endfunction

	task automatic run_random(int count);
		repeat (count) send_word(random_word());
	endtask

	task automatic test_directed();
		send_word(make_word(REQ_NONE, 10'd0, 8'd0, 0, 0, 0));
		send_word(make_word(REQ_UPDATE, 10'd0, 8'd0, 1, 1, 0));
		send_word(make_word(REQ_UPDATE, 10'd0, 8'd0, 1, 0, 1));
		send_word(make_word(REQ_UPDATE, 10'd0, 8'd0, 0, 1, 1));
		send_word(make_word(REQ_UPDATE, 10'd0, 8'd0, 1, 1, 1));
		send_word(make_word(REQ_UPDATE, 10'd1023, 8'd255, 1, 1, 1));
		send_word(make_word(REQ_NORM, 10'd1023, 8'd255, 0, 0, 0));
		repeat (6) send_word(make_word(REQ_UPDATE, 10'd1023, 8'd255, 0, 1, 1));
		send_word(make_word(REQ_NORM, 10'd1023, 8'd255, 1, 1, 1));
		send_word(make_word(REQ_NORM, 10'd0, 8'd255, 0, 0, 1));
		send_word(make_word(REQ_NONE, 10'd1023, 8'd255, 1, 1, 1));
		send_word(make_word(REQ_CLEAR, 10'd1023, 8'd255, 0, 0, 0));
		send_word(make_word(REQ_NORM, 10'd1023, 8'd255, 0, 0, 0));
		send_word(make_word(REQ_CLEAR, 10'd0, 8'd0, 1, 1, 1));
	endtask

	task automatic test_default_config();
		run_random(250);
		no_idle = 1'b1;
		run_random(200);
		no_idle = 1'b0;
	endtask

	task automatic test_fast_learning();
		set_config(16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd32768, 24'd65536);
		run_random(350);
	endtask

	task automatic test_floor_above_ceiling();
		set_config(16'd0, 16'd1000, 16'd20000, 16'd32768, 16'd0, 24'd0);
		run_random(250);
	endtask

	task automatic test_random_config();
		repeat (3) begin
			set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)),
				16'($urandom_range(0, 32768)), 24'($urandom_range(0, 400000)));
			run_random(200);
		end
	endtask

	task automatic test_limit_max();
		set_config(16'd64238, 16'd655, 16'd328, 16'd328, 16'd32768, 24'hFFFFFF);
		run_random(150);
	endtask

	initial begin
		cfg_decay = 16'd64238;
		cfg_pot = 16'd655;
		cfg_dep = 16'd328;
		cfg_floor = 16'd328;
		cfg_ceil = 16'd32768;
		cfg_limit = 24'd163840;
		for (int i = 0; i < SYNAPSES_DEF; i++) begin
			weight_mem[i] = WEIGHT_ONE;
			pre_tr_mem[i] = '0;
			post_tr_mem[i] = '0;
		end
		for (int i = 0; i < NEURONS_DEF; i++) sum_mem[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_default_config();
		test_fast_learning();
		test_floor_above_ceiling();
		test_random_config();
		test_limit_max();
		drain_block();
		$display("Sent %0d words and checked %0d results, %0d of them scaled,",
			words_sent, words_checked, scaled_seen);
		$display("across default, extreme and random register settings.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("Timeout with %0d results outstanding", expected_words.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: stdp_synapse_weight_update.f
rtl/core/stdp_pkg.sv
rtl/core/stdp_cfg_regs.sv
rtl/core/stdp_ctrl.sv
rtl/core/stdp_datapath.sv
rtl/core/stdp_synapse_weight_update.sv
rtl/core/stdp_checker.sv
tb/testbench.sv
